/* rtl/hcaf_pkg.sv */
// hcaf_pkg: widths, register indexes, phase and status codes and helpers
// for the hill-climb autofocus controller; no dependencies
package hcaf_pkg;

    localparam int PosBits  = 16;
    localparam int ConBits  = 32;
    localparam int StepBits = 13;
    localparam int SkipBits = 8;
    localparam int IdxBits  = 3;

    localparam int LensBits = PosBits + 2;   // lens position with step headroom
    localparam int PeakBits = PosBits + 1;
    localparam int RawBits  = PosBits + 4;   // signed move target before saturation

    typedef logic [PosBits-1:0]  pos_t;
    typedef logic [LensBits-1:0] lens_t;
    typedef logic [PeakBits-1:0] peak_t;
    typedef logic [StepBits-1:0] step_t;
    typedef logic [SkipBits-1:0] skip_t;
    typedef logic [ConBits-1:0]  con_t;
    typedef logic signed [RawBits-1:0] raw_t;

    // configuration register indexes
    localparam logic [IdxBits-1:0] RegMinPos     = 3'd0;
    localparam logic [IdxBits-1:0] RegMaxPos     = 3'd1;
    localparam logic [IdxBits-1:0] RegCoarseStep = 3'd2;
    localparam logic [IdxBits-1:0] RegFineStep   = 3'd3;
    localparam logic [IdxBits-1:0] RegFineWindow = 3'd4;
    localparam logic [IdxBits-1:0] RegSkipFrames = 3'd5;

    // search phases
    localparam logic [2:0] PhReset  = 3'd0;
    localparam logic [2:0] PhSettle = 3'd1;
    localparam logic [2:0] PhCoarse = 3'd2;
    localparam logic [2:0] PhFine   = 3'd3;
    localparam logic [2:0] PhStop   = 3'd4;

    // reported status
    localparam logic [2:0] StSkip   = 3'd0;
    localparam logic [2:0] StReset  = 3'd1;
    localparam logic [2:0] StSettle = 3'd2;
    localparam logic [2:0] StCoarse = 3'd3;
    localparam logic [2:0] StFine   = 3'd4;
    localparam logic [2:0] StStop   = 3'd5;

    // clamp a signed position into 0 .. 2^PosBits-1
    function automatic pos_t sat_pos(input raw_t v);
        pos_t res;
        if (v[RawBits-1])
        begin
            res = '0;
        end
        else if (v[RawBits-2:PosBits] != '0)
        begin
            res = '1;
        end
        else
        begin
            res = v[PosBits-1:0];
        end
        return res;
    endfunction

    // position minus one, as a signed raw target
    function automatic raw_t pos_minus_one(input lens_t p);
        raw_t res;
        res = raw_t'({{(RawBits-LensBits){1'b0}}, p}) - raw_t'(1);
        return res;
    endfunction

endpackage

/* rtl/hill_climb_autofocus_controller.sv */
// hill_climb_autofocus_controller: contrast hill-climb lens focus search
// depends on hcaf_pkg (widths, codes, saturation helpers)
//
// usage
//   in channel: one transfer per frame event (frame_present, contrast)
//   out channel: one result transfer per input item (status, move_count,
//     move_target, best_position)
//   both channels use valid/stall; a transfer happens when valid is high
//   and stall is low at a rising clk edge
//   cfg port: cfg_we writes cfg_data into register cfg_index; the user must
//     write only while the block is idle, the block does not enforce this
// timing
//   an accepted item is held in the input register, the whole search step
//   is worked out in one pass and lands in the result register
//   one item per cycle sustained while out_stall is low; the single-pass
//   step logic and the search state registers allow that rate
// reset
//   rst_n clears both stages, loads the register defaults and restarts the
//   search in the reset phase
// stall
//   a stalled result holds in the result register; one more item may still
//   be taken into the input register, after which in_stall rises
module hill_climb_autofocus_controller
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       frame_present,
    input  logic [hcaf_pkg::ConBits-1:0] contrast,

    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [2:0]                 status,
    output logic [1:0]                 move_count,
    output logic [hcaf_pkg::PosBits-1:0] move_target,
    output logic [hcaf_pkg::PosBits-1:0] best_position,

    input  logic                       cfg_we,
    input  logic [hcaf_pkg::IdxBits-1:0] cfg_index,
    input  logic [hcaf_pkg::PosBits-1:0] cfg_data
);

    // configuration registers
    hcaf_pkg::pos_t  min_pos_reg;
    hcaf_pkg::pos_t  max_pos_reg;
    hcaf_pkg::step_t coarse_step_reg;
    hcaf_pkg::step_t fine_step_reg;
    hcaf_pkg::step_t fine_window_reg;
    hcaf_pkg::skip_t skip_frames_reg;

    // search state
    logic [2:0]      phase_reg,   phase_next;
    hcaf_pkg::lens_t lens_reg,    lens_next;
    hcaf_pkg::con_t  peak_con_reg, peak_con_next;
    hcaf_pkg::peak_t peak_pos_reg, peak_pos_next;
    hcaf_pkg::peak_t limit_reg,   limit_next;
    hcaf_pkg::skip_t skip_reg,    skip_next;

    // input stage
    logic            in_valid_reg;
    logic            frame_reg;
    hcaf_pkg::con_t  con_reg;

    // result stage
    logic            out_valid_reg;
    logic [2:0]      status_reg,  status_next;
    logic [1:0]      count_reg,   count_next;
    hcaf_pkg::pos_t  target_reg;
    hcaf_pkg::pos_t  best_reg;
    hcaf_pkg::raw_t  target_raw;

    logic            advance;
    logic            in_take;

    // step arithmetic
    logic            skipped;
    hcaf_pkg::skip_t skip_inc;
    logic            new_peak;
    hcaf_pkg::con_t  peak_con_upd;
    hcaf_pkg::peak_t peak_pos_upd;
    hcaf_pkg::lens_t coarse_sum;
    hcaf_pkg::lens_t fine_sum;
    hcaf_pkg::lens_t win_ext;
    hcaf_pkg::lens_t lim_sum;
    hcaf_pkg::lens_t fine_start;
    hcaf_pkg::peak_t fine_lim;
    logic [hcaf_pkg::LensBits:0]  fine_reach;
    logic [hcaf_pkg::ConBits+1:0] con_x4;
    logic [hcaf_pkg::ConBits+1:0] peak_x3;
    logic            fine_done;

    // handshake: the step runs when the input stage holds an item and the
    // result stage is empty or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // measurement skip counter
    assign skipped  = skip_reg < skip_frames_reg;
    assign skip_inc = skip_reg + hcaf_pkg::skip_t'(1);

    // peak tracking includes the current frame
    assign new_peak     = con_reg > peak_con_reg;
    assign peak_con_upd = new_peak ? con_reg : peak_con_reg;
    assign peak_pos_upd = new_peak ? lens_reg[hcaf_pkg::PeakBits-1:0] : peak_pos_reg;

    assign win_ext    = hcaf_pkg::lens_t'(fine_window_reg);
    assign coarse_sum = lens_reg + hcaf_pkg::lens_t'(coarse_step_reg);
    assign fine_sum   = lens_reg + hcaf_pkg::lens_t'(fine_step_reg);

    // fine window around the coarse peak: start clamped to 1, end to max
    assign lim_sum    = hcaf_pkg::lens_t'(peak_pos_upd) + win_ext;
    assign fine_start = (hcaf_pkg::lens_t'(peak_pos_upd) > win_ext)
                        ? hcaf_pkg::lens_t'(peak_pos_upd) - win_ext
                        : hcaf_pkg::lens_t'(1);
    assign fine_lim   = (lim_sum > hcaf_pkg::lens_t'(max_pos_reg))
                        ? hcaf_pkg::peak_t'(max_pos_reg)
                        : lim_sum[hcaf_pkg::PeakBits-1:0];

    // stop at limit, or early: past (limit - window) and contrast <= 75% of peak
    assign fine_reach = {1'b0, fine_sum} + {1'b0, win_ext};
    assign con_x4     = {con_reg, 2'b00};
    assign peak_x3    = {1'b0, peak_con_upd, 1'b0} + {2'b00, peak_con_upd};
    assign fine_done  = (fine_sum >= hcaf_pkg::lens_t'(limit_reg))
                     || ((fine_reach > (hcaf_pkg::LensBits+1)'(limit_reg))
                         && (con_x4 <= peak_x3));

    always_comb
    begin
        phase_next    = phase_reg;
        lens_next     = lens_reg;
        peak_con_next = peak_con_reg;
        peak_pos_next = peak_pos_reg;
        limit_next    = limit_reg;
        skip_next     = skip_reg;
        status_next   = hcaf_pkg::StSkip;
        count_next    = 2'd0;
        target_raw    = '0;

        if (frame_reg)
        begin
            case (phase_reg)
                hcaf_pkg::PhReset:
                begin
                    status_next = hcaf_pkg::StReset;
                    lens_next   = hcaf_pkg::lens_t'(min_pos_reg);
                    count_next  = 2'd1;
                    target_raw  = hcaf_pkg::raw_t'(min_pos_reg);
                    phase_next  = hcaf_pkg::PhSettle;
                end
                hcaf_pkg::PhSettle:
                begin
                    status_next = hcaf_pkg::StSettle;
                    if (skipped)
                    begin
                        skip_next = skip_inc;
                    end
                    else
                    begin
                        skip_next  = '0;
                        phase_next = hcaf_pkg::PhCoarse;
                    end
                end
                hcaf_pkg::PhCoarse:
                begin
                    if (skipped)
                    begin
                        skip_next = skip_inc;
                    end
                    else
                    begin
                        skip_next     = '0;
                        status_next   = hcaf_pkg::StCoarse;
                        peak_con_next = peak_con_upd;
                        peak_pos_next = peak_pos_upd;
                        if (coarse_sum >= hcaf_pkg::lens_t'(max_pos_reg))
                        begin
                            // coarse sweep done: jump to the fine window start
                            lens_next  = fine_start;
                            limit_next = fine_lim;
                            count_next = 2'd2;
                            phase_next = hcaf_pkg::PhFine;
                            target_raw = hcaf_pkg::pos_minus_one(fine_start);
                        end
                        else
                        begin
                            lens_next  = coarse_sum;
                            count_next = 2'd1;
                            target_raw = hcaf_pkg::pos_minus_one(coarse_sum);
                        end
                    end
                end
                hcaf_pkg::PhFine:
                begin
                    if (skipped)
                    begin
                        skip_next = skip_inc;
                    end
                    else
                    begin
                        skip_next     = '0;
                        status_next   = hcaf_pkg::StFine;
                        peak_con_next = peak_con_upd;
                        peak_pos_next = peak_pos_upd;
                        lens_next     = fine_sum;
                        if (fine_done)
                        begin
                            // park on the best position found
                            count_next = 2'd2;
                            phase_next = hcaf_pkg::PhStop;
                            target_raw = hcaf_pkg::pos_minus_one(
                                             hcaf_pkg::lens_t'(peak_pos_upd));
                        end
                        else
                        begin
                            count_next = 2'd1;
                            target_raw = hcaf_pkg::pos_minus_one(fine_sum);
                        end
                    end
                end
                default:
                begin
                    // stop phase and unused codes restart the search
                    status_next   = hcaf_pkg::StStop;
                    phase_next    = hcaf_pkg::PhReset;
                    lens_next     = hcaf_pkg::lens_t'(min_pos_reg);
                    peak_con_next = '0;
                    peak_pos_next = '0;
                    limit_next    = '0;
                    skip_next     = '0;
                end
            endcase
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_pos_reg     <= hcaf_pkg::pos_t'(0);
            max_pos_reg     <= hcaf_pkg::pos_t'(1023);
            coarse_step_reg <= hcaf_pkg::step_t'(32);
            fine_step_reg   <= hcaf_pkg::step_t'(4);
            fine_window_reg <= hcaf_pkg::step_t'(32);
            skip_frames_reg <= hcaf_pkg::skip_t'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hcaf_pkg::RegMinPos:     min_pos_reg     <= cfg_data;
                hcaf_pkg::RegMaxPos:     max_pos_reg     <= cfg_data;
                hcaf_pkg::RegCoarseStep: coarse_step_reg <= cfg_data[hcaf_pkg::StepBits-1:0];
                hcaf_pkg::RegFineStep:   fine_step_reg   <= cfg_data[hcaf_pkg::StepBits-1:0];
                hcaf_pkg::RegFineWindow: fine_window_reg <= cfg_data[hcaf_pkg::StepBits-1:0];
                hcaf_pkg::RegSkipFrames: skip_frames_reg <= cfg_data[hcaf_pkg::SkipBits-1:0];
                default:                 ;
            endcase
        end
    end

    // search state, updated once per processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= hcaf_pkg::PhReset;
            lens_reg     <= '0;
            peak_con_reg <= '0;
            peak_pos_reg <= '0;
            limit_reg    <= '0;
            skip_reg     <= '0;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            lens_reg     <= lens_next;
            peak_con_reg <= peak_con_next;
            peak_pos_reg <= peak_pos_next;
            limit_reg    <= limit_next;
            skip_reg     <= skip_next;
        end
    end

    // input and result stage valid control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= (in_valid_reg && !advance) || in_take;
            out_valid_reg <= advance || (out_valid_reg && out_stall);
        end
    end

    // input payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            frame_reg <= frame_present;
            con_reg   <= contrast;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg <= status_next;
            count_reg  <= count_next;
            target_reg <= (count_next != 2'd0) ? hcaf_pkg::sat_pos(target_raw) : '0;
            best_reg   <= hcaf_pkg::sat_pos(hcaf_pkg::raw_t'(peak_pos_next));
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign move_count    = count_reg;
    assign move_target   = target_reg;
    assign best_position = best_reg;

endmodule
